// ===== rtl/gfd_pkg.sv =====
// package for the gateway frame deframer: word types, status codes, config register indices
// no dependencies
package gfd_pkg;
  localparam int DEVICE_CODE_BYTES_DEF = 4;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_last;
  } in_word_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status_code;
    logic [31:0] device_code;
    logic [7:0]  message_type;
    logic [7:0]  version_byte;
    logic [7:0]  direction_byte;
    logic [15:0] payload_length;
    logic [15:0] frame_offset;
    logic [15:0] frame_bytes;
    logic        run_last;
  } out_word_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_NOHEADER = 3'd2;
  localparam logic [2:0] ST_NOEND    = 3'd3;
  localparam logic [2:0] ST_BADSUM   = 3'd4;

  localparam logic [1:0] REG_HEADER = 2'd0;
  localparam logic [1:0] REG_START  = 2'd1;
  localparam logic [1:0] REG_END    = 2'd2;
endpackage

// ===== rtl/gfd_front.sv =====
// front part: parses one byte per cycle while take is high and builds result words
// depends on gfd_pkg
`default_nettype none
module gfd_front #(
  parameter int DEVICE_CODE_BYTES = gfd_pkg::DEVICE_CODE_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [7:0]         cfg_data,
  input  wire logic               take,
  input  wire gfd_pkg::in_word_t  in_word,
  output gfd_pkg::out_word_t      pay_word,
  output logic                    pay_en,
  output gfd_pkg::out_word_t      st_word,
  output logic                    st_en
);
  import gfd_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT, PH_CODE, PH_LENHI, PH_LENLO, PH_PAYLOAD, PH_SUM, PH_ENDB, PH_DONE
  } phase_t;

  localparam int MinBuffer = DEVICE_CODE_BYTES + 10;
  localparam int CodeSeg = DEVICE_CODE_BYTES + 5;
  localparam logic [16:0] MinLen = 17'(MinBuffer);
  localparam logic [16:0] Fixed = 17'(DEVICE_CODE_BYTES + 11);

  logic [7:0] header_byte, start_byte, end_byte;
  phase_t phase;
  logic [15:0] pos, hpos, cnt, len;
  logic [7:0] prev, rsum, rxsum;
  logic prev_valid;
  logic [31:0] code;
  logic [7:0] mtype, ver, dir;
  logic [2:0] verdict;

  logic [7:0] b;
  logic [16:0] blen, fsum;
  logic [2:0] status;
  logic [15:0] len_next;
  out_word_t pay_build;
  assign b = in_word.rx_byte;
  assign blen = {1'b0, pos} + 17'd1;
  assign len_next = {len[15:8], b};
  assign fsum = Fixed + {1'b0, len};

  // payload word: only the byte is set
  always_comb begin
    pay_build = '0;
    pay_build.payload_byte = b;
  end

  always_comb begin
    priority if (blen < MinLen) status = ST_SHORT;
    else if (phase == PH_HUNT || ({1'b0, hpos} + 17'd2 >= blen)) status = ST_NOHEADER;
    else if (!(phase == PH_ENDB || phase == PH_DONE)) status = ST_NOEND;
    else if (phase == PH_ENDB) begin
      if (b != end_byte) status = ST_NOEND;
      else status = (rsum == rxsum) ? ST_OK : ST_BADSUM;
    end else status = verdict;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= '0; start_byte <= '0; end_byte <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEADER: header_byte <= cfg_data;
        REG_START:  start_byte <= cfg_data;
        REG_END:    end_byte <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT; pos <= '0; hpos <= '0; cnt <= '0; len <= '0;
      prev <= '0; rsum <= '0; rxsum <= '0; prev_valid <= 1'b0;
      code <= '0; mtype <= '0; ver <= '0; dir <= '0; verdict <= '0;
      pay_en <= 1'b0; st_en <= 1'b0;
    end else begin
      pay_en <= 1'b0;
      st_en <= 1'b0;
      if (take) begin
        pay_word <= pay_build;
        unique case (phase)
          PH_HUNT: if (prev_valid && prev == header_byte && b == start_byte) begin
            hpos <= pos - 16'd1; cnt <= '0; phase <= PH_CODE;
          end
          PH_CODE: begin
            if (cnt < 16'(DEVICE_CODE_BYTES)) code <= {code[23:0], b};
            else if (cnt == 16'(DEVICE_CODE_BYTES)) mtype <= b;
            else if (cnt == 16'(DEVICE_CODE_BYTES + 1)) ver <= b;
            else if (cnt == 16'(DEVICE_CODE_BYTES + 2)) dir <= b;
            cnt <= cnt + 16'd1;
            if (cnt + 16'd1 >= 16'(CodeSeg)) phase <= PH_LENHI;
          end
          PH_LENHI: begin len <= {b, 8'd0}; phase <= PH_LENLO; end
          PH_LENLO: begin
            len <= len_next; cnt <= '0;
            phase <= (len_next != 16'd0) ? PH_PAYLOAD : PH_SUM;
          end
          PH_PAYLOAD: begin
            pay_en <= 1'b1;
            rsum <= rsum + b;
            cnt <= cnt + 16'd1;
            if (cnt + 16'd1 >= len) phase <= PH_SUM;
          end
          PH_SUM: begin rxsum <= b; phase <= PH_ENDB; end
          PH_ENDB: begin
            if (b != end_byte) verdict <= ST_NOEND;
            else verdict <= (rsum == rxsum) ? ST_OK : ST_BADSUM;
            phase <= PH_DONE;
          end
          default: ;
        endcase
        prev <= b;
        prev_valid <= 1'b1;
        if (in_word.buffer_last) begin
          st_en <= 1'b1;
          st_word.item_kind <= 1'b1;
          st_word.payload_byte <= '0;
          st_word.status_code <= status;
          st_word.device_code <= (phase == PH_CODE && cnt < 16'(DEVICE_CODE_BYTES))
                                 ? {code[23:0], b} : code;
          st_word.message_type <= (phase == PH_CODE && cnt == 16'(DEVICE_CODE_BYTES))
                                  ? b : mtype;
          st_word.version_byte <= (phase == PH_CODE && cnt == 16'(DEVICE_CODE_BYTES + 1))
                                  ? b : ver;
          st_word.direction_byte <= (phase == PH_CODE && cnt == 16'(DEVICE_CODE_BYTES + 2))
                                    ? b : dir;
          st_word.payload_length <= (phase == PH_LENHI) ? {b, 8'd0} :
                                    (phase == PH_LENLO) ? len_next : len;
          st_word.frame_offset <= (phase == PH_HUNT && prev_valid && prev == header_byte
                                   && b == start_byte) ? pos - 16'd1 : hpos;
          st_word.frame_bytes <= (status == ST_OK) ? (fsum[16] ? 16'hffff : fsum[15:0])
                                                   : 16'd0;
          st_word.run_last <= 1'b1;
          phase <= PH_HUNT; pos <= '0; hpos <= '0; cnt <= '0; len <= '0;
          prev <= '0; rsum <= '0; rxsum <= '0; prev_valid <= 1'b0;
          code <= '0; mtype <= '0; ver <= '0; dir <= '0; verdict <= '0;
        end else if (pos != 16'hffff) begin
          pos <= pos + 16'd1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/gfd_queue.sv =====
// back part: small result queue driving the output channel
// depends on gfd_pkg
`default_nettype none
module gfd_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire gfd_pkg::out_word_t pay_word,
  input  wire logic               pay_en,
  input  wire gfd_pkg::out_word_t st_word,
  input  wire logic               st_en,
  output logic                    room,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output gfd_pkg::out_word_t      out_word
);
  import gfd_pkg::*;

  out_word_t mem [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  logic pop;
  logic [1:0] push_n;

  assign out_valid = cnt != 3'd0;
  assign out_word = mem[rp];
  assign pop = out_valid && !out_stall;
  assign push_n = {1'b0, pay_en} + {1'b0, st_en};
  // two words may arrive in a cycle, and two more may be in flight
  assign room = (cnt + {1'b0, push_n}) <= (pop ? 3'd3 : 3'd2);

  always_ff @(posedge clk) begin
    if (pay_en) mem[wp] <= pay_word;
    if (st_en) mem[pay_en ? wp + 2'd1 : wp] <= st_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      wp <= wp + push_n;
      if (pop) rp <= rp + 2'd1;
      cnt <= cnt + {1'b0, push_n} - {2'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/gateway_frame_deframer_core.sv =====
// top level of the gateway frame deframer
// depends on gfd_pkg, gfd_front, gfd_queue
// usage:
//   input channel in_valid/in_stall/in_word carries one buffer byte per word,
//   buffer_last marks the final byte of a buffer
//   output channel out_valid/out_stall/out_word carries payload bytes
//   (item_kind 0) and one status word per buffer (item_kind 1, run_last)
//   config: cfg_we/cfg_index/cfg_data write header, start and end bytes
// path: a result word is registered in the front, then written into the queue
// throughput: one byte per cycle while the output is taken every cycle;
//   a final payload byte yields two words, which a four-entry queue absorbs
//   and drains at one word per cycle, so one byte per cycle overall holds
//   except right after such a byte when the queue is near full
// the parser front and the queue back are decoupled; the input is stalled
//   only when the queue might overflow
// reset: synchronous, clears control and config registers to zero and the parser to hunting
// stall on the output holds the head word and backs up into the input
`default_nettype none
module gateway_frame_deframer_core #(
  parameter int DEVICE_CODE_BYTES = gfd_pkg::DEVICE_CODE_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [7:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire gfd_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output gfd_pkg::out_word_t      out_word
);
  import gfd_pkg::*;

  out_word_t pay_word, st_word;
  logic pay_en, st_en, room, take;

  // front writes reach the queue in the cycle after take; guard for words in flight
  assign in_stall = !room;
  assign take = in_valid && room;

  gfd_front #(.DEVICE_CODE_BYTES(DEVICE_CODE_BYTES)) u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .take, .in_word,
    .pay_word, .pay_en, .st_word, .st_en
  );

  gfd_queue u_queue (
    .clk, .rst, .pay_word, .pay_en, .st_word, .st_en, .room,
    .out_valid, .out_stall, .out_word
  );
endmodule
`default_nettype wire
